// File: rtl/dsfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsfc_pkg;

    localparam int ID_W     = 64;
    localparam int AGE_W    = 64;
    localparam int ENB_W    = 3;
    localparam int MAXAGE_W = 63;
    localparam int FAULT_W  = 4;
    localparam int NUM_CNT  = 4;

    // check enable bits
    localparam int ENB_STAMP = 0;
    localparam int ENB_ID    = 1;
    localparam int ENB_MONO  = 2;

    // fault bits, also the counter order
    localparam int FLT_MISSING  = 0;
    localparam int FLT_STALE    = 1;
    localparam int FLT_ZERO_ID  = 2;
    localparam int FLT_BACKWARD = 3;

    // configuration register indexes
    localparam logic [1:0] REG_EST_ENABLES = 2'd0;
    localparam logic [1:0] REG_EST_MAX_AGE = 2'd1;
    localparam logic [1:0] REG_INT_ENABLES = 2'd2;
    localparam logic [1:0] REG_INT_MAX_AGE = 2'd3;

    typedef struct packed {
        logic [ENB_W-1:0]    enables;
        logic [MAXAGE_W-1:0] max_age;
    } lane_cfg_t;

    typedef struct packed {
        logic [FAULT_W-1:0]     faults;
        logic signed [AGE_W-1:0] age;
    } lane_res_t;

endpackage

`default_nettype wire

// File: rtl/dsfc_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module dsfc_lane #(
    parameter int COUNTER_WIDTH = 32,
    parameter int TIME_WIDTH    = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                accept,
    input  wire logic [63:0]                         now_time,
    input  wire logic [63:0]                         stamp,
    input  wire logic [dsfc_pkg::ID_W-1:0]           id,
    input  wire logic                                track_enable,
    input  wire dsfc_pkg::lane_cfg_t                 cfg,
    output dsfc_pkg::lane_res_t                      res,
    output logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] cnt_next
);

    logic [dsfc_pkg::ID_W-1:0]                       last_id_reg;
    logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] cnt_reg;

    logic [TIME_WIDTH-1:0]        now_t;
    logic [TIME_WIDTH-1:0]        stamp_t;
    logic signed [TIME_WIDTH-1:0] diff;
    logic signed [dsfc_pkg::AGE_W-1:0] age_ext;
    logic                         present;
    logic [dsfc_pkg::FAULT_W-1:0] faults;

    assign now_t   = now_time[TIME_WIDTH-1:0];
    assign stamp_t = stamp[TIME_WIDTH-1:0];
    assign present = (stamp_t != '0);
    assign diff    = signed'(now_t - stamp_t);
    assign age_ext = dsfc_pkg::AGE_W'(diff);

    always_comb begin
        faults = '0;
        faults[dsfc_pkg::FLT_MISSING] = cfg.enables[dsfc_pkg::ENB_STAMP] && !present;
        // future stamps give a negative age and are never stale
        faults[dsfc_pkg::FLT_STALE] = present && !age_ext[dsfc_pkg::AGE_W-1] &&
            (unsigned'(age_ext) > {1'b0, cfg.max_age});
        faults[dsfc_pkg::FLT_ZERO_ID] = cfg.enables[dsfc_pkg::ENB_ID] && (id == '0);
        faults[dsfc_pkg::FLT_BACKWARD] = cfg.enables[dsfc_pkg::ENB_MONO] &&
            (id != '0) && (last_id_reg != '0) && (id < last_id_reg);
    end

    assign res.faults = faults;
    assign res.age    = present ? age_ext : '0;

    always_comb begin
        for (int i = 0; i < dsfc_pkg::NUM_CNT; i++) begin
            cnt_next[i] = cnt_reg[i];
            // saturate at all ones
            if (track_enable && faults[i] && (cnt_reg[i] != '1)) begin
                cnt_next[i] = cnt_reg[i] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_id_reg <= '0;
            cnt_reg     <= '0;
        end else if (accept && track_enable) begin
            cnt_reg <= cnt_next;
            if (id != '0) begin
                last_id_reg <= id;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/dsfc_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module dsfc_merge #(
    parameter int COUNTER_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dsfc_pkg::lane_res_t est_res,
    input  wire dsfc_pkg::lane_res_t int_res,
    input  wire logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] est_cnt,
    input  wire logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] int_cnt,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dsfc_pkg::lane_res_t      est_out,
    output dsfc_pkg::lane_res_t      int_out,
    output logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] est_cnt_out,
    output logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] int_cnt_out
);

    logic valid_reg;
    logic valid_next;
    logic fire;

    dsfc_pkg::lane_res_t est_out_reg;
    dsfc_pkg::lane_res_t int_out_reg;
    logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] est_cnt_out_reg;
    logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] int_cnt_out_reg;

    assign s_ready    = !valid_reg || m_ready;
    assign fire       = s_valid && s_ready;
    assign valid_next = fire || (valid_reg && !m_ready);
    assign m_valid    = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // load the result beat whenever the output slot frees up
    always_ff @(posedge aclk) begin
        if (fire) begin
            est_out_reg     <= est_res;
            int_out_reg     <= int_res;
            est_cnt_out_reg <= est_cnt;
            int_cnt_out_reg <= int_cnt;
        end
    end

    assign est_out     = est_out_reg;
    assign int_out     = int_out_reg;
    assign est_cnt_out = est_cnt_out_reg;
    assign int_cnt_out = int_cnt_out_reg;

endmodule

`default_nettype wire

// File: rtl/dual_stream_freshness_check_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake         | payload
// input    | in        | s_valid / s_ready | now_time, stamps, ids, track_enable
// result   | out       | m_valid / m_ready | faults, ages, eight fault counters
// config   | in        | APB psel/penable  | four registers at 8-byte stride
//
// One item per cycle while m_ready holds; a beat accepted at an edge sits in a single output
// register and is offered on the result port from that edge, leaving when m_ready takes it.
// Both stream lanes check at the accept edge, and update ids and counters there when track_enable is set.
// s_ready is high while the output register is empty or being taken.
// Reset (aresetn low, synchronous) clears config registers, output valid, last ids and counters.

module dual_stream_freshness_check_core #(
    parameter int COUNTER_WIDTH = 32,
    parameter int TIME_WIDTH    = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [4:0]               paddr,
    input  wire logic [63:0]              pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [63:0]              s_now_time,
    input  wire logic [63:0]              s_estimator_stamp,
    input  wire logic [63:0]              s_estimator_id,
    input  wire logic [63:0]              s_intent_stamp,
    input  wire logic [63:0]              s_intent_id,
    input  wire logic                     s_track_enable,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [3:0]                    m_estimator_faults,
    output logic signed [63:0]            m_estimator_age,
    output logic [3:0]                    m_intent_faults,
    output logic signed [63:0]            m_intent_age,
    output logic [COUNTER_WIDTH-1:0]      m_est_missing_count,
    output logic [COUNTER_WIDTH-1:0]      m_est_stale_count,
    output logic [COUNTER_WIDTH-1:0]      m_est_zero_id_count,
    output logic [COUNTER_WIDTH-1:0]      m_est_backward_count,
    output logic [COUNTER_WIDTH-1:0]      m_int_missing_count,
    output logic [COUNTER_WIDTH-1:0]      m_int_stale_count,
    output logic [COUNTER_WIDTH-1:0]      m_int_zero_id_count,
    output logic [COUNTER_WIDTH-1:0]      m_int_backward_count
);

    dsfc_pkg::lane_cfg_t est_cfg_reg;
    dsfc_pkg::lane_cfg_t int_cfg_reg;

    logic       cfg_wr;
    logic [1:0] cfg_idx;
    logic       accept;

    dsfc_pkg::lane_res_t est_res;
    dsfc_pkg::lane_res_t int_res;
    dsfc_pkg::lane_res_t est_out;
    dsfc_pkg::lane_res_t int_out;
    logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] est_cnt;
    logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] int_cnt;
    logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] est_cnt_out;
    logic [dsfc_pkg::NUM_CNT-1:0][COUNTER_WIDTH-1:0] int_cnt_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:3];
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_cfg_reg <= '0;
            int_cfg_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                dsfc_pkg::REG_EST_ENABLES: begin
                    est_cfg_reg.enables <= pwdata[dsfc_pkg::ENB_W-1:0];
                end
                dsfc_pkg::REG_EST_MAX_AGE: begin
                    est_cfg_reg.max_age <= pwdata[dsfc_pkg::MAXAGE_W-1:0];
                end
                dsfc_pkg::REG_INT_ENABLES: begin
                    int_cfg_reg.enables <= pwdata[dsfc_pkg::ENB_W-1:0];
                end
                dsfc_pkg::REG_INT_MAX_AGE: begin
                    int_cfg_reg.max_age <= pwdata[dsfc_pkg::MAXAGE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            dsfc_pkg::REG_EST_ENABLES: prdata = 64'(est_cfg_reg.enables);
            dsfc_pkg::REG_EST_MAX_AGE: prdata = 64'(est_cfg_reg.max_age);
            dsfc_pkg::REG_INT_ENABLES: prdata = 64'(int_cfg_reg.enables);
            dsfc_pkg::REG_INT_MAX_AGE: prdata = 64'(int_cfg_reg.max_age);
            default:                   prdata = '0;
        endcase
    end

    dsfc_lane #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_est_lane (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .now_time     (s_now_time),
        .stamp        (s_estimator_stamp),
        .id           (s_estimator_id),
        .track_enable (s_track_enable),
        .cfg          (est_cfg_reg),
        .res          (est_res),
        .cnt_next     (est_cnt)
    );

    dsfc_lane #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_int_lane (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .now_time     (s_now_time),
        .stamp        (s_intent_stamp),
        .id           (s_intent_id),
        .track_enable (s_track_enable),
        .cfg          (int_cfg_reg),
        .res          (int_res),
        .cnt_next     (int_cnt)
    );

    dsfc_merge #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .est_res     (est_res),
        .int_res     (int_res),
        .est_cnt     (est_cnt),
        .int_cnt     (int_cnt),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .est_out     (est_out),
        .int_out     (int_out),
        .est_cnt_out (est_cnt_out),
        .int_cnt_out (int_cnt_out)
    );

    assign m_estimator_faults   = est_out.faults;
    assign m_estimator_age      = est_out.age;
    assign m_intent_faults      = int_out.faults;
    assign m_intent_age         = int_out.age;
    assign m_est_missing_count  = est_cnt_out[dsfc_pkg::FLT_MISSING];
    assign m_est_stale_count    = est_cnt_out[dsfc_pkg::FLT_STALE];
    assign m_est_zero_id_count  = est_cnt_out[dsfc_pkg::FLT_ZERO_ID];
    assign m_est_backward_count = est_cnt_out[dsfc_pkg::FLT_BACKWARD];
    assign m_int_missing_count  = int_cnt_out[dsfc_pkg::FLT_MISSING];
    assign m_int_stale_count    = int_cnt_out[dsfc_pkg::FLT_STALE];
    assign m_int_zero_id_count  = int_cnt_out[dsfc_pkg::FLT_ZERO_ID];
    assign m_int_backward_count = int_cnt_out[dsfc_pkg::FLT_BACKWARD];

endmodule

`default_nettype wire

// File: tb/freshness_monitor.sv
`timescale 1ns / 1ps

module freshness_monitor #(
    parameter int CW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [4:0]           paddr,
    input  logic [63:0]          pwdata,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [63:0]          s_now_time,
    input  logic [63:0]          s_estimator_stamp,
    input  logic [63:0]          s_estimator_id,
    input  logic [63:0]          s_intent_stamp,
    input  logic [63:0]          s_intent_id,
    input  logic                 s_track_enable,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [3:0]           m_estimator_faults,
    input  logic [63:0]          m_estimator_age,
    input  logic [3:0]           m_intent_faults,
    input  logic [63:0]          m_intent_age,
    input  logic [CW-1:0]        m_est_missing_count,
    input  logic [CW-1:0]        m_est_stale_count,
    input  logic [CW-1:0]        m_est_zero_id_count,
    input  logic [CW-1:0]        m_est_backward_count,
    input  logic [CW-1:0]        m_int_missing_count,
    input  logic [CW-1:0]        m_int_stale_count,
    input  logic [CW-1:0]        m_int_zero_id_count,
    input  logic [CW-1:0]        m_int_backward_count,

    output int                   mismatch_total,
    output int                   outstanding,
    output int                   checked_total
);

    localparam int LANE_EST = 0;
    localparam int LANE_INT = 1;
    localparam int NCNT     = dsfc_pkg::NUM_CNT;

    typedef struct packed {
        logic [dsfc_pkg::FAULT_W-1:0] est_faults;
        logic [dsfc_pkg::AGE_W-1:0]   est_age;
        logic [dsfc_pkg::FAULT_W-1:0] int_faults;
        logic [dsfc_pkg::AGE_W-1:0]   int_age;
        logic [2*NCNT-1:0][CW-1:0]    counts;
    } verdict_t;

    string count_names [2*NCNT] = '{
        "est_missing_count", "est_stale_count", "est_zero_id_count", "est_backward_count",
        "int_missing_count", "int_stale_count", "int_zero_id_count", "int_backward_count"
    };

    logic [dsfc_pkg::ENB_W-1:0]    lane_enables [2];
    logic [dsfc_pkg::MAXAGE_W-1:0] lane_max_age [2];
    logic [dsfc_pkg::ID_W-1:0]     lane_last_id [2];
    logic [CW-1:0]                 lane_counts  [2][NCNT];

    verdict_t awaited_verdicts [$];

    initial begin
        mismatch_total = 0;
        outstanding    = 0;
        checked_total  = 0;
    end

    function automatic void bump_count(input int lane, input int kind, input logic track);
        if (track && lane_counts[lane][kind] != '1) begin
            lane_counts[lane][kind] = lane_counts[lane][kind] + 1'b1;
        end
    endfunction

    function automatic void judge_lane(
        input  int                           lane,
        input  logic [63:0]                  now,
        input  logic [63:0]                  stamp,
        input  logic [dsfc_pkg::ID_W-1:0]    id,
        input  logic                         track,
        output logic [dsfc_pkg::FAULT_W-1:0] faults,
        output logic [dsfc_pkg::AGE_W-1:0]   age
    );
        faults = '0;
        age    = '0;
        if (lane_enables[lane][dsfc_pkg::ENB_STAMP] && stamp == '0) begin
            faults[dsfc_pkg::FLT_MISSING] = 1'b1;
            bump_count(lane, dsfc_pkg::FLT_MISSING, track);
        end
        if (stamp != '0) begin
            // wraps modulo 2^64; a set top bit means a stamp from the future
            age = now - stamp;
            if (!age[dsfc_pkg::AGE_W-1] && age > {1'b0, lane_max_age[lane]}) begin
                faults[dsfc_pkg::FLT_STALE] = 1'b1;
                bump_count(lane, dsfc_pkg::FLT_STALE, track);
            end
        end
        if (lane_enables[lane][dsfc_pkg::ENB_ID] && id == '0) begin
            faults[dsfc_pkg::FLT_ZERO_ID] = 1'b1;
            bump_count(lane, dsfc_pkg::FLT_ZERO_ID, track);
        end
        if (lane_enables[lane][dsfc_pkg::ENB_MONO] && id != '0 && lane_last_id[lane] != '0
                && id < lane_last_id[lane]) begin
            faults[dsfc_pkg::FLT_BACKWARD] = 1'b1;
            bump_count(lane, dsfc_pkg::FLT_BACKWARD, track);
        end
        if (track && id != '0) begin
            lane_last_id[lane] = id;
        end
    endfunction

    function automatic verdict_t freshness_verdict(
        input logic [63:0] now,
        input logic [63:0] est_stamp,
        input logic [63:0] est_id,
        input logic [63:0] int_stamp,
        input logic [63:0] int_id,
        input logic        track
    );
        verdict_t v;
        judge_lane(LANE_EST, now, est_stamp, est_id, track, v.est_faults, v.est_age);
        judge_lane(LANE_INT, now, int_stamp, int_id, track, v.int_faults, v.int_age);
        for (int k = 0; k < NCNT; k++) begin
            v.counts[k]        = lane_counts[LANE_EST][k];
            v.counts[NCNT + k] = lane_counts[LANE_INT][k];
        end
        return v;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        verdict_t got;
        if (!aresetn) begin
            for (int l = 0; l < 2; l++) begin
                lane_enables[l] = '0;
                lane_max_age[l] = '0;
                lane_last_id[l] = '0;
                for (int k = 0; k < NCNT; k++) lane_counts[l][k] = '0;
            end
            awaited_verdicts.delete();
        end else begin
            // check the leaving beat first: it belongs to an earlier input
            if (m_valid && m_ready) begin
                got.est_faults = m_estimator_faults;
                got.est_age    = m_estimator_age;
                got.int_faults = m_intent_faults;
                got.int_age    = m_intent_age;
                got.counts     = {m_int_backward_count, m_int_zero_id_count,
                                  m_int_stale_count, m_int_missing_count,
                                  m_est_backward_count, m_est_zero_id_count,
                                  m_est_stale_count, m_est_missing_count};
                if (awaited_verdicts.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h", $time, got);
                    mismatch_total++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    compare_field("estimator_faults", want.est_faults, got.est_faults);
                    compare_field("estimator_age", want.est_age, got.est_age);
                    compare_field("intent_faults", want.int_faults, got.int_faults);
                    compare_field("intent_age", want.int_age, got.int_age);
                    for (int k = 0; k < 2*NCNT; k++) begin
                        compare_field(count_names[k], want.counts[k], got.counts[k]);
                    end
                    checked_total++;
                end
            end
            if (s_valid && s_ready) begin
                awaited_verdicts.push_back(freshness_verdict(s_now_time, s_estimator_stamp,
                    s_estimator_id, s_intent_stamp, s_intent_id, s_track_enable));
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    dsfc_pkg::REG_EST_ENABLES:
                        lane_enables[LANE_EST] = pwdata[dsfc_pkg::ENB_W-1:0];
                    dsfc_pkg::REG_EST_MAX_AGE:
                        lane_max_age[LANE_EST] = pwdata[dsfc_pkg::MAXAGE_W-1:0];
                    dsfc_pkg::REG_INT_ENABLES:
                        lane_enables[LANE_INT] = pwdata[dsfc_pkg::ENB_W-1:0];
                    dsfc_pkg::REG_INT_MAX_AGE:
                        lane_max_age[LANE_INT] = pwdata[dsfc_pkg::MAXAGE_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = awaited_verdicts.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CW          = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_BEATS = 170;
    localparam logic [63:0] AGE_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_now_time = '0;
    logic [63:0] s_estimator_stamp = '0;
    logic [63:0] s_estimator_id = '0;
    logic [63:0] s_intent_stamp = '0;
    logic [63:0] s_intent_id = '0;
    logic        s_track_enable = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_estimator_faults;
    logic [63:0] m_estimator_age;
    logic [3:0]  m_intent_faults;
    logic [63:0] m_intent_age;
    logic [CW-1:0] m_est_missing_count, m_est_stale_count;
    logic [CW-1:0] m_est_zero_id_count, m_est_backward_count;
    logic [CW-1:0] m_int_missing_count, m_int_stale_count;
    logic [CW-1:0] m_int_zero_id_count, m_int_backward_count;

    int mismatch_total;
    int outstanding;
    int checked_total;

    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int beats_sent = 0;
    int reg_writes = 0;

    logic [63:0] now_base;
    logic [63:0] est_seq;
    logic [63:0] int_seq;

    always #5 aclk = ~aclk;

    dual_stream_freshness_check_core #(
        .COUNTER_WIDTH(CW),
        .TIME_WIDTH   (64)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_now_time          (s_now_time),
        .s_estimator_stamp   (s_estimator_stamp),
        .s_estimator_id      (s_estimator_id),
        .s_intent_stamp      (s_intent_stamp),
        .s_intent_id         (s_intent_id),
        .s_track_enable      (s_track_enable),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_estimator_faults  (m_estimator_faults),
        .m_estimator_age     (m_estimator_age),
        .m_intent_faults     (m_intent_faults),
        .m_intent_age        (m_intent_age),
        .m_est_missing_count (m_est_missing_count),
        .m_est_stale_count   (m_est_stale_count),
        .m_est_zero_id_count (m_est_zero_id_count),
        .m_est_backward_count(m_est_backward_count),
        .m_int_missing_count (m_int_missing_count),
        .m_int_stale_count   (m_int_stale_count),
        .m_int_zero_id_count (m_int_zero_id_count),
        .m_int_backward_count(m_int_backward_count)
    );

    freshness_monitor #(.CW(CW)) monitor (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .pready              (pready),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_now_time          (s_now_time),
        .s_estimator_stamp   (s_estimator_stamp),
        .s_estimator_id      (s_estimator_id),
        .s_intent_stamp      (s_intent_stamp),
        .s_intent_id         (s_intent_id),
        .s_track_enable      (s_track_enable),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_estimator_faults  (m_estimator_faults),
        .m_estimator_age     (m_estimator_age),
        .m_intent_faults     (m_intent_faults),
        .m_intent_age        (m_intent_age),
        .m_est_missing_count (m_est_missing_count),
        .m_est_stale_count   (m_est_stale_count),
        .m_est_zero_id_count (m_est_zero_id_count),
        .m_est_backward_count(m_est_backward_count),
        .m_int_missing_count (m_int_missing_count),
        .m_int_stale_count   (m_int_stale_count),
        .m_int_zero_id_count (m_int_zero_id_count),
        .m_int_backward_count(m_int_backward_count),
        .mismatch_total      (mismatch_total),
        .outstanding         (outstanding),
        .checked_total       (checked_total)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random back-pressure, or a long hold when one is requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_ticket != hold_served) begin
                hold_served = hold_ticket;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // called at a falling edge, returns at the falling edge after the write
    task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        reg_writes++;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_beat(input logic [63:0] now, input logic [63:0] est_stamp,
                              input logic [63:0] est_id, input logic [63:0] int_stamp,
                              input logic [63:0] int_id, input logic track);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid           = 1'b1;
        s_now_time        = now;
        s_estimator_stamp = est_stamp;
        s_estimator_id    = est_id;
        s_intent_stamp    = int_stamp;
        s_intent_id       = int_id;
        s_track_enable    = track;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        beats_sent++;
    endtask

    // drop valid and let every expected beat drain before touching registers
    task automatic drain();
        s_valid = 1'b0;
        wait (outstanding == 0);
        repeat (3) @(negedge aclk);
    endtask

    function automatic logic [63:0] pick_stamp(input logic [63:0] now, input int reach);
        case ($urandom_range(19))
            0, 1:    return '0;
            2, 3:    return now + $urandom_range(1, 50);
            4:       return rand64();
            default: return now - $urandom_range(0, reach);
        endcase
    endfunction

    function automatic logic [63:0] pick_id(input logic [63:0] last);
        case ($urandom_range(19))
            0, 1:    return '0;
            2, 3:    return last - $urandom_range(1, 20);
            4:       return last;
            5:       return rand64();
            default: return last + $urandom_range(1, 4);
        endcase
    endfunction

    task automatic run_phase(input int s_pct, input int r_pct, input logic [63:0] base,
                             input logic [63:0] est_en, input logic [63:0] est_max,
                             input logic [63:0] int_en, input logic [63:0] int_max,
                             input logic hold);
        logic [63:0] now;
        logic [63:0] est_id;
        logic [63:0] int_id;
        int est_reach;
        int int_reach;
        drain();
        reg_write(dsfc_pkg::REG_EST_ENABLES, est_en);
        reg_write(dsfc_pkg::REG_EST_MAX_AGE, est_max);
        reg_write(dsfc_pkg::REG_INT_ENABLES, int_en);
        reg_write(dsfc_pkg::REG_INT_MAX_AGE, int_max);
        est_reach = (est_max[62:0] < 1000) ? 2 * int'(est_max[62:0]) + 2 : 2000;
        int_reach = (int_max[62:0] < 1000) ? 2 * int'(int_max[62:0]) + 2 : 2000;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        now_base = base;
        if (hold) hold_ticket++;
        for (int n = 0; n < PHASE_BEATS; n++) begin
            if ($urandom_range(19) == 0) begin
                now_base = rand64();
            end else begin
                now_base = now_base + $urandom_range(1, 30);
            end
            now    = now_base;
            est_id = pick_id(est_seq);
            int_id = pick_id(int_seq);
            if (est_id != '0) est_seq = est_id;
            if (int_id != '0) int_seq = int_id;
            offer_beat(now, pick_stamp(now, est_reach), est_id,
                       pick_stamp(now, int_reach), int_id, $urandom_range(9) < 8);
        end
    endtask

    initial begin
        est_seq = 64'd1;
        int_seq = 64'd1;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        recv_idle_pct = 30;

        // registers at reset: no enables, zero age limit
        offer_beat('0, '0, '0, '0, '0, 1'b1);
        offer_beat(64'd1000, 64'd1000, 64'd5, 64'd999, 64'd5, 1'b1);
        offer_beat(64'd10, 64'd20, 64'd3, 64'd11, 64'd2, 1'b1);

        // all checks on; write masked bits too
        drain();
        reg_write(dsfc_pkg::REG_EST_ENABLES, '1);
        reg_write(dsfc_pkg::REG_EST_MAX_AGE, 64'd100);
        reg_write(dsfc_pkg::REG_INT_ENABLES, '1);
        reg_write(dsfc_pkg::REG_INT_MAX_AGE, '1);
        offer_beat('1, '1, '1, '1, '1, 1'b1);
        // wrap: now below stamp by modular arithmetic gives small positive age
        offer_beat('0, '1, 64'd10, '1, 64'd10, 1'b1);
        offer_beat('1, 64'd1, 64'd10, 64'd1, 64'd10, 1'b1);
        // largest positive age: stale against 100, equal to the top limit
        offer_beat(64'h8000_0000_0000_0000, 64'd1, 64'd9, 64'd1, 64'd9, 1'b0);
        offer_beat(64'h8000_0000_0000_0001, 64'd1, 64'd9, 64'd1, 64'd9, 1'b0);
        offer_beat(64'd500, 64'd400, 64'd11, 64'd399, 64'd11, 1'b1);
        offer_beat(64'd500, 64'd399, 64'd11, 64'd400, 64'd11, 1'b1);
        offer_beat(64'd600, '0, '0, '0, '0, 1'b1);
        offer_beat(64'd700, '0, 64'd3, 64'd650, 64'd3, 1'b1);
        offer_beat(64'd700, 64'd650, 64'd3, '0, 64'd2, 1'b0);

        // estimator checks off, intent stamp check on; estimator limit at its top value, intent limit zero
        drain();
        reg_write(dsfc_pkg::REG_EST_ENABLES, '0);
        reg_write(dsfc_pkg::REG_EST_MAX_AGE, AGE_TOP);
        reg_write(dsfc_pkg::REG_INT_ENABLES, 64'd1);
        reg_write(dsfc_pkg::REG_INT_MAX_AGE, '0);
        offer_beat(64'd800, '0, 64'd1, '0, '0, 1'b1);
        offer_beat(64'd800, 64'd1, 64'd2, 64'd800, 64'd1, 1'b1);
        offer_beat(64'd800, 64'd801, '0, 64'd799, 64'h8000_0000_0000_0000, 1'b1);

        run_phase(29, 51, rand64(), $urandom_range(0, 7), $urandom_range(0, 200),
                  $urandom_range(0, 7), $urandom_range(0, 200), 1'b1);
        run_phase(51, 29, 64'hFFFF_FFFF_FFFF_F000, 64'd7, 64'd0,
                  $urandom_range(0, 7), AGE_TOP, 1'b0);
        run_phase(0, 0, rand64(), $urandom_range(0, 7), $urandom_range(0, 500),
                  64'd7, 64'd50, 1'b0);

        drain();
        repeat (5) @(posedge aclk);
        $display("%0d input beats under %0d register writes, %0d result beats compared",
                 beats_sent, reg_writes, checked_total);
        $display("phases: idle sender/receiver mixes, long result hold, time wrap, age limits");
        if (mismatch_total == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/dsfc_pkg.sv
rtl/dsfc_lane.sv
rtl/dsfc_merge.sv
rtl/dual_stream_freshness_check_core.sv
tb/freshness_monitor.sv
tb/tb_top.sv
